// ----- rtl/owsu_pkg.sv -----
// shared types and constants for the one-wire uart sequencer
`default_nettype none

package owsu_pkg;

	localparam int CMD_W     = 4;
	localparam int CFG_W     = 24;
	localparam int DELAY_W   = 16;
	localparam int BYTE_W    = 8;
	localparam int KIND_W    = 3;
	localparam int ENTRY_W   = KIND_W + DELAY_W;
	localparam int WAIT_W    = 32;
	localparam int WAIT_FRAC = 8;
	localparam int PROD_W    = CFG_W + DELAY_W;
	localparam int STATUS_W  = 2;

	localparam logic [CFG_W-1:0] CFG_RESET = 24'd256;

	localparam logic [CMD_W-1:0] CMD_ADD_WRITE = 4'd0;
	localparam logic [CMD_W-1:0] CMD_ADD_READ  = 4'd1;
	localparam logic [CMD_W-1:0] CMD_ADD_RESET = 4'd2;
	localparam logic [CMD_W-1:0] CMD_ADD_WAIT  = 4'd3;
	localparam logic [CMD_W-1:0] CMD_CLEAR     = 4'd4;
	localparam logic [CMD_W-1:0] CMD_START     = 4'd5;
	localparam logic [CMD_W-1:0] CMD_TX_DONE   = 4'd6;
	localparam logic [CMD_W-1:0] CMD_TICK      = 4'd7;
	localparam logic [CMD_W-1:0] CMD_POP       = 4'd8;

	localparam logic [KIND_W-1:0] KIND_W0   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_W1   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_RD   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_RST  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_WAIT = 3'd4;

	localparam logic [BYTE_W-1:0] BYTE_LOW   = 8'h00;
	localparam logic [BYTE_W-1:0] BYTE_HIGH  = 8'hFF;
	localparam logic [BYTE_W-1:0] BYTE_RESET = 8'hF0;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_FIN,
		ST_START,
		ST_LOAD,
		ST_MUL,
		ST_POP,
		ST_EMIT
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LATCH,
		OP_APPEND,
		OP_CLEAR,
		OP_START_INIT,
		OP_TICK,
		OP_POP_RD,
		OP_POP_TAKE,
		OP_POP_EMPTY,
		OP_FIN_RD,
		OP_FIN,
		OP_CUR_RD,
		OP_SET_READY,
		OP_LOAD,
		OP_WAIT_SET,
		OP_EMIT
	} op_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             fin_ok;
		logic             waiting;
		logic             wait_last;
		logic             rx_avail;
		logic             seq_end;
		logic             cur_wait;
		logic             out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/owsu_ram.sv -----
// generic single write port ram with registered read
`default_nettype none

module owsu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/owsu_ctrl.sv -----
// sequencer controller state machine
`default_nettype none

module owsu_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cmd_valid,
	output logic                   cmd_stall,
	input  wire owsu_pkg::dp_stat_t stat,
	output owsu_pkg::op_t          op
);

	owsu_pkg::state_t state_q;
	owsu_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= owsu_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			owsu_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					state_d = owsu_pkg::ST_EXEC;
				end
			end
			owsu_pkg::ST_EXEC: begin
				unique case (stat.cmd) inside
					owsu_pkg::CMD_START: state_d = owsu_pkg::ST_START;
					owsu_pkg::CMD_TX_DONE: begin
						state_d = stat.fin_ok ? owsu_pkg::ST_FIN : owsu_pkg::ST_EMIT;
					end
					owsu_pkg::CMD_TICK: begin
						state_d = (stat.waiting && stat.wait_last) ?
							owsu_pkg::ST_START : owsu_pkg::ST_EMIT;
					end
					owsu_pkg::CMD_POP: begin
						state_d = stat.rx_avail ? owsu_pkg::ST_POP : owsu_pkg::ST_EMIT;
					end
					default: state_d = owsu_pkg::ST_EMIT;
				endcase
			end
			owsu_pkg::ST_FIN: state_d = owsu_pkg::ST_START;
			owsu_pkg::ST_START: begin
				state_d = stat.seq_end ? owsu_pkg::ST_EMIT : owsu_pkg::ST_LOAD;
			end
			owsu_pkg::ST_LOAD: begin
				state_d = stat.cur_wait ? owsu_pkg::ST_MUL : owsu_pkg::ST_EMIT;
			end
			owsu_pkg::ST_MUL: state_d = owsu_pkg::ST_EMIT;
			owsu_pkg::ST_POP: state_d = owsu_pkg::ST_EMIT;
			owsu_pkg::ST_EMIT: begin
				if (stat.out_free) begin
					state_d = owsu_pkg::ST_IDLE;
				end
			end
			default: state_d = owsu_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		op        = owsu_pkg::OP_NONE;
		cmd_stall = (state_q != owsu_pkg::ST_IDLE);
		unique case (state_q)
			owsu_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					op = owsu_pkg::OP_LATCH;
				end
			end
			owsu_pkg::ST_EXEC: begin
				unique case (stat.cmd) inside
					owsu_pkg::CMD_ADD_WRITE, owsu_pkg::CMD_ADD_READ,
					owsu_pkg::CMD_ADD_RESET, owsu_pkg::CMD_ADD_WAIT: begin
						op = owsu_pkg::OP_APPEND;
					end
					owsu_pkg::CMD_CLEAR: op = owsu_pkg::OP_CLEAR;
					owsu_pkg::CMD_START: op = owsu_pkg::OP_START_INIT;
					owsu_pkg::CMD_TX_DONE: begin
						op = stat.fin_ok ? owsu_pkg::OP_FIN_RD : owsu_pkg::OP_NONE;
					end
					owsu_pkg::CMD_TICK: op = owsu_pkg::OP_TICK;
					owsu_pkg::CMD_POP: begin
						op = stat.rx_avail ? owsu_pkg::OP_POP_RD : owsu_pkg::OP_POP_EMPTY;
					end
					default: op = owsu_pkg::OP_NONE;
				endcase
			end
			owsu_pkg::ST_FIN: op = owsu_pkg::OP_FIN;
			owsu_pkg::ST_START: begin
				op = stat.seq_end ? owsu_pkg::OP_SET_READY : owsu_pkg::OP_CUR_RD;
			end
			owsu_pkg::ST_LOAD: op = owsu_pkg::OP_LOAD;
			owsu_pkg::ST_MUL: op = owsu_pkg::OP_WAIT_SET;
			owsu_pkg::ST_POP: op = owsu_pkg::OP_POP_TAKE;
			owsu_pkg::ST_EMIT: begin
				if (stat.out_free) begin
					op = owsu_pkg::OP_EMIT;
				end
			end
			default: op = owsu_pkg::OP_NONE;
		endcase
	end

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall) |=> (state_q == owsu_pkg::ST_EXEC))
		else $error("accepted beat did not enter execute");

	a_load_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == owsu_pkg::ST_LOAD) |-> ($past(state_q) == owsu_pkg::ST_START))
		else $error("element load without a start");

	a_mul_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == owsu_pkg::ST_MUL) |-> ($past(state_q) == owsu_pkg::ST_LOAD))
		else $error("wait setup without an element load");

endmodule

`default_nettype wire

// ----- rtl/owsu_dp.sv -----
// sequencer datapath: sequence store, read-bit store, flags and result register
`default_nettype none

module owsu_dp #(
	parameter int SEQ_DEPTH = 64,
	parameter int RX_DEPTH  = 64
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire owsu_pkg::op_t                     op,
	output owsu_pkg::dp_stat_t                     stat,
	input  wire logic [owsu_pkg::CMD_W-1:0]        cmd,
	input  wire logic                              write_bit,
	input  wire logic [owsu_pkg::DELAY_W-1:0]      wait_ms,
	input  wire logic [owsu_pkg::BYTE_W-1:0]       rx_byte,
	input  wire logic                              cfg_wen,
	input  wire logic [owsu_pkg::CFG_W-1:0]        cfg_wdata,
	output logic                                   rsp_valid,
	input  wire logic                              rsp_stall,
	output logic                                   tx_valid,
	output logic      [owsu_pkg::BYTE_W-1:0]       tx_byte,
	output logic                                   slow_baud,
	output logic                                   seq_ready,
	output logic                                   presence,
	output logic                                   read_bit,
	output logic                                   read_valid,
	output logic      [owsu_pkg::STATUS_W-1:0]     status
);

	localparam int SEQ_AW = $clog2(SEQ_DEPTH);
	localparam int SEQ_CW = $clog2(SEQ_DEPTH + 1);
	localparam int RX_AW  = $clog2(RX_DEPTH);
	localparam int RX_CW  = $clog2(RX_DEPTH + 1);

	logic [owsu_pkg::CFG_W-1:0]    cfg_q;
	logic [owsu_pkg::CMD_W-1:0]    cmd_q;
	logic                          wbit_q;
	logic [owsu_pkg::DELAY_W-1:0]  dly_q;
	logic [owsu_pkg::BYTE_W-1:0]   rx_q;
	logic [SEQ_CW-1:0]             seq_count_q;
	logic [SEQ_CW-1:0]             exec_q;
	logic [RX_CW-1:0]              rx_wr_q;
	logic [RX_CW-1:0]              rx_rd_q;
	logic [owsu_pkg::WAIT_W-1:0]   wait_left_q;
	logic                          waiting_q;
	logic                          ready_q;
	logic                          presence_q;
	logic                          slow_q;
	logic [owsu_pkg::PROD_W-1:0]   prod_q;
	logic                          tx_v_q;
	logic [owsu_pkg::BYTE_W-1:0]   tx_b_q;
	logic                          rbit_q;
	logic                          rvalid_q;
	logic [owsu_pkg::STATUS_W-1:0] status_q;
	logic                          rsp_valid_q;

	logic                          seq_full;
	logic [SEQ_CW-1:0]             fin_idx;
	logic [owsu_pkg::KIND_W-1:0]   new_kind;
	logic [owsu_pkg::DELAY_W-1:0]  new_dly;
	logic [owsu_pkg::KIND_W-1:0]   rd_kind;
	logic                          seq_we;
	logic                          seq_re;
	logic [SEQ_AW-1:0]             seq_raddr;
	logic [owsu_pkg::ENTRY_W-1:0]  seq_wdata;
	logic [owsu_pkg::ENTRY_W-1:0]  seq_rdata;
	logic                          rx_we;
	logic                          rx_re;
	logic                          rx_wdata;
	logic                          rx_rdata;
	logic                          out_free;

	assign seq_full = (seq_count_q == SEQ_CW'(SEQ_DEPTH));
	assign fin_idx  = exec_q - SEQ_CW'(1);
	assign rd_kind  = seq_rdata[owsu_pkg::ENTRY_W-1:owsu_pkg::DELAY_W];
	assign out_free = !rsp_valid_q || !rsp_stall;

	always_comb begin
		new_dly = '0;
		case (cmd_q) inside
			owsu_pkg::CMD_ADD_WRITE: begin
				new_kind = wbit_q ? owsu_pkg::KIND_W1 : owsu_pkg::KIND_W0;
			end
			owsu_pkg::CMD_ADD_READ:  new_kind = owsu_pkg::KIND_RD;
			owsu_pkg::CMD_ADD_RESET: new_kind = owsu_pkg::KIND_RST;
			default: begin
				new_kind = owsu_pkg::KIND_WAIT;
				new_dly  = dly_q;
			end
		endcase
	end

	assign seq_wdata = {new_kind, new_dly};
	assign seq_we    = (op == owsu_pkg::OP_APPEND) && !seq_full;
	assign seq_re    = (op == owsu_pkg::OP_FIN_RD) || (op == owsu_pkg::OP_CUR_RD);
	assign seq_raddr = (op == owsu_pkg::OP_FIN_RD) ? fin_idx[SEQ_AW-1:0] : exec_q[SEQ_AW-1:0];

	assign rx_we    = (op == owsu_pkg::OP_FIN) && (rd_kind == owsu_pkg::KIND_RD) &&
		(rx_wr_q < RX_CW'(RX_DEPTH));
	assign rx_wdata = (rx_q == owsu_pkg::BYTE_HIGH);
	assign rx_re    = (op == owsu_pkg::OP_POP_RD);

	owsu_ram #(
		.WIDTH (owsu_pkg::ENTRY_W),
		.DEPTH (SEQ_DEPTH)
	) u_seq_ram (
		.clk   (clk),
		.we    (seq_we),
		.waddr (seq_count_q[SEQ_AW-1:0]),
		.wdata (seq_wdata),
		.re    (seq_re),
		.raddr (seq_raddr),
		.rdata (seq_rdata)
	);

	owsu_ram #(
		.WIDTH (1),
		.DEPTH (RX_DEPTH)
	) u_rx_ram (
		.clk   (clk),
		.we    (rx_we),
		.waddr (rx_wr_q[RX_AW-1:0]),
		.wdata (rx_wdata),
		.re    (rx_re),
		.raddr (rx_rd_q[RX_AW-1:0]),
		.rdata (rx_rdata)
	);

	// beat fields and per-beat scratch
	always_ff @(posedge clk) begin
		unique case (op)
			owsu_pkg::OP_LATCH: begin
				cmd_q    <= cmd;
				wbit_q   <= write_bit;
				dly_q    <= wait_ms;
				rx_q     <= rx_byte;
				tx_v_q   <= 1'b0;
				tx_b_q   <= owsu_pkg::BYTE_LOW;
				rbit_q   <= 1'b0;
				rvalid_q <= 1'b0;
				status_q <= owsu_pkg::STATUS_OK;
			end
			owsu_pkg::OP_APPEND: begin
				if (seq_full) begin
					status_q <= owsu_pkg::STATUS_FULL;
				end
			end
			owsu_pkg::OP_POP_EMPTY: status_q <= owsu_pkg::STATUS_EMPTY;
			owsu_pkg::OP_POP_TAKE: begin
				rbit_q   <= rx_rdata;
				rvalid_q <= 1'b1;
			end
			owsu_pkg::OP_LOAD: begin
				case (rd_kind)
					owsu_pkg::KIND_W0: begin
						tx_v_q <= 1'b1;
						tx_b_q <= owsu_pkg::BYTE_LOW;
					end
					owsu_pkg::KIND_W1, owsu_pkg::KIND_RD: begin
						tx_v_q <= 1'b1;
						tx_b_q <= owsu_pkg::BYTE_HIGH;
					end
					owsu_pkg::KIND_RST: begin
						tx_v_q <= 1'b1;
						tx_b_q <= owsu_pkg::BYTE_RESET;
					end
					default: begin
					end
				endcase
				prod_q <= owsu_pkg::PROD_W'(cfg_q) *
					owsu_pkg::PROD_W'(seq_rdata[owsu_pkg::DELAY_W-1:0]);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q       <= owsu_pkg::CFG_RESET;
			seq_count_q <= '0;
			exec_q      <= '0;
			rx_wr_q     <= '0;
			rx_rd_q     <= '0;
			wait_left_q <= '0;
			waiting_q   <= 1'b0;
			ready_q     <= 1'b0;
			presence_q  <= 1'b0;
			slow_q      <= 1'b0;
		end else begin
			if (cfg_wen) begin
				cfg_q <= cfg_wdata;
			end
			unique case (op)
				owsu_pkg::OP_APPEND: begin
					if (!seq_full) begin
						seq_count_q <= seq_count_q + SEQ_CW'(1);
					end
				end
				owsu_pkg::OP_CLEAR: seq_count_q <= '0;
				owsu_pkg::OP_START_INIT: begin
					exec_q      <= '0;
					rx_wr_q     <= '0;
					rx_rd_q     <= '0;
					ready_q     <= 1'b0;
					waiting_q   <= 1'b0;
					wait_left_q <= '0;
				end
				owsu_pkg::OP_TICK: begin
					if (waiting_q) begin
						if (wait_left_q != '0) begin
							wait_left_q <= wait_left_q - owsu_pkg::WAIT_W'(1);
						end
						if (stat.wait_last) begin
							waiting_q <= 1'b0;
						end
					end
				end
				owsu_pkg::OP_POP_RD: rx_rd_q <= rx_rd_q + RX_CW'(1);
				owsu_pkg::OP_FIN: begin
					if (rx_we) begin
						rx_wr_q <= rx_wr_q + RX_CW'(1);
					end
					if (rd_kind == owsu_pkg::KIND_RST) begin
						presence_q <= (rx_q != owsu_pkg::BYTE_HIGH);
						slow_q     <= 1'b0;
					end
				end
				owsu_pkg::OP_CUR_RD: exec_q <= exec_q + SEQ_CW'(1);
				owsu_pkg::OP_SET_READY: ready_q <= 1'b1;
				owsu_pkg::OP_LOAD: begin
					if (rd_kind == owsu_pkg::KIND_RST) begin
						slow_q <= 1'b1;
					end
				end
				owsu_pkg::OP_WAIT_SET: begin
					wait_left_q <= prod_q[owsu_pkg::PROD_W-1:owsu_pkg::WAIT_FRAC] +
						owsu_pkg::WAIT_W'(1);
					waiting_q   <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (op == owsu_pkg::OP_EMIT) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (op == owsu_pkg::OP_EMIT) begin
			tx_valid   <= tx_v_q;
			tx_byte    <= tx_b_q;
			slow_baud  <= slow_q;
			seq_ready  <= ready_q;
			presence   <= presence_q;
			read_bit   <= rbit_q;
			read_valid <= rvalid_q;
			status     <= status_q;
		end
	end

	assign rsp_valid = rsp_valid_q;

	always_comb begin
		stat.cmd       = cmd_q;
		stat.fin_ok    = !waiting_q && !ready_q && (exec_q != '0);
		stat.waiting   = waiting_q;
		stat.wait_last = (wait_left_q[owsu_pkg::WAIT_W-1:1] == '0);
		stat.rx_avail  = (rx_rd_q < rx_wr_q);
		stat.seq_end   = (exec_q >= seq_count_q);
		stat.cur_wait  = (rd_kind == owsu_pkg::KIND_WAIT);
		stat.out_free  = out_free;
	end

	a_rd_behind_wr: assert property (@(posedge clk) disable iff (!arst_n)
		rx_rd_q <= rx_wr_q)
		else $error("read-bit pop passed the write position");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_count_q <= SEQ_CW'(SEQ_DEPTH)) && (rx_wr_q <= RX_CW'(RX_DEPTH)))
		else $error("store position beyond depth");

	a_wait_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!(waiting_q && ready_q))
		else $error("waiting and ready both set");

endmodule

`default_nettype wire

// ----- rtl/one_wire_uart_sequencer_unit.sv -----
// one-wire master sequencer over a byte uart: top level
// append, clear and ignored events run from acceptance through execute to the result beat,
// a pop adds the read-bit fetch, start, tx done and an expiring tick the element fetch and
// the wait multiply, on the single read port of the sequence ram; a command beat is taken
// only once the last has emitted its result, which waits while the result register is stalled
// reset clears all control state and counters, sets the tick scale to 256 and leaves both
// stores unwritten
`default_nettype none

module one_wire_uart_sequencer_unit #(
	parameter int SEQ_DEPTH = 64,
	parameter int RX_DEPTH  = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wen,
	input  wire logic [owsu_pkg::CFG_W-1:0]    cfg_wdata,
	input  wire logic                          cmd_valid,
	output logic                               cmd_stall,
	input  wire logic [owsu_pkg::CMD_W-1:0]    cmd,
	input  wire logic                          write_bit,
	input  wire logic [owsu_pkg::DELAY_W-1:0]  wait_ms,
	input  wire logic [owsu_pkg::BYTE_W-1:0]   rx_byte,
	output logic                               rsp_valid,
	input  wire logic                          rsp_stall,
	output logic                               tx_valid,
	output logic      [owsu_pkg::BYTE_W-1:0]   tx_byte,
	output logic                               slow_baud,
	output logic                               seq_ready,
	output logic                               presence,
	output logic                               read_bit,
	output logic                               read_valid,
	output logic      [owsu_pkg::STATUS_W-1:0] status
);

	owsu_pkg::op_t      op;
	owsu_pkg::dp_stat_t stat;

	owsu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.stat      (stat),
		.op        (op)
	);

	owsu_dp #(
		.SEQ_DEPTH (SEQ_DEPTH),
		.RX_DEPTH  (RX_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (op),
		.stat       (stat),
		.cmd        (cmd),
		.write_bit  (write_bit),
		.wait_ms    (wait_ms),
		.rx_byte    (rx_byte),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.tx_valid   (tx_valid),
		.tx_byte    (tx_byte),
		.slow_baud  (slow_baud),
		.seq_ready  (seq_ready),
		.presence   (presence),
		.read_bit   (read_bit),
		.read_valid (read_valid),
		.status     (status)
	);

endmodule

`default_nettype wire
